### sv/dmbc_pkg.sv
// ----------------------------------------------------------------------------
// dmbc_pkg
// Shared types and constants for the direct-mapped block cache store.
// ----------------------------------------------------------------------------
package dmbc_pkg;

  localparam int unsigned BLOCK_BYTES      = 64;
  localparam int unsigned CACHE_LINES      = 256;
  localparam int unsigned STORE_BLOCKS_DEF = 4096;

  localparam int unsigned WORD_BYTES      = 8;
  localparam int unsigned WORDS_PER_BLOCK = BLOCK_BYTES / WORD_BYTES;
  localparam int unsigned WSEL_W          = $clog2(WORDS_PER_BLOCK);
  localparam int unsigned BOFF_W          = $clog2(BLOCK_BYTES);
  localparam int unsigned BSEL_W          = $clog2(WORD_BYTES);
  localparam int unsigned LINE_W          = $clog2(CACHE_LINES);
  localparam int unsigned UIDX_W          = 18;
  localparam int unsigned BADDR_W         = UIDX_W + 3;

  // every byte of an untouched unit holds a newline
  localparam logic [63:0] FILL_WORD = {WORD_BYTES{8'h0A}};

  localparam logic [1:0] USIZE_RESET = 2'd2;

  localparam logic REQ_SET = 1'b0;
  localparam logic REQ_GET = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNSET = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic              req_type;
    logic [UIDX_W-1:0] unit_index;
    logic [63:0]       write_value;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] read_value;
    logic        was_hit;
    logic        did_writeback;
  } rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_WB,
    S_FILL,
    S_REREAD,
    S_ACCESS,
    S_RESP
  } state_t;

endpackage

### sv/dmbc_unit_merge.sv
// ----------------------------------------------------------------------------
// dmbc_unit_merge
// Places a unit into a 64-bit line word and pulls a unit out of it.
// ----------------------------------------------------------------------------
module dmbc_unit_merge import dmbc_pkg::*; (
  input  logic [1:0]        unit_size_log2,
  input  logic [BSEL_W-1:0] byte_off,
  input  logic [63:0]       old_word,
  input  logic [63:0]       write_value,
  output logic [63:0]       new_word,
  output logic [63:0]       unit_value,
  output logic              unset
);

  logic [63:0] unit_mask;
  logic [63:0] word_mask;
  logic [5:0]  bit_sh;

  always_comb begin
    unique case (unit_size_log2)
      2'd0:    unit_mask = 64'h0000_0000_0000_00FF;
      2'd1:    unit_mask = 64'h0000_0000_0000_FFFF;
      2'd2:    unit_mask = 64'h0000_0000_FFFF_FFFF;
      default: unit_mask = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
  end

  // units are aligned, so one never straddles two words
  assign bit_sh     = {byte_off, 3'b000};
  assign word_mask  = unit_mask << bit_sh;
  assign new_word   = (old_word & ~word_mask) | ((write_value << bit_sh) & word_mask);
  assign unit_value = (old_word >> bit_sh) & unit_mask;
  assign unset      = (unit_value == (FILL_WORD & unit_mask));

endmodule

### sv/direct_mapped_block_cache_store.sv
// Hit: the request passes through the lookup, access and response states; a new request is
// taken only once the block is back in idle. Miss on an empty line: an eight-word fill, then a
// re-read of the word and the access. Miss on a valid line: an eight-word write-back, then the fill.
// Out of range: straight to the response state. The memory ports move one word per cycle.
// After reset a clearing pass writes 0x0A to every store word, during which no
// request is taken; the register port is open throughout.
// ----------------------------------------------------------------------------
// direct_mapped_block_cache_store
// Unit store behind a direct-mapped write-back block cache, memory based.
// ----------------------------------------------------------------------------
module direct_mapped_block_cache_store import dmbc_pkg::*; #(
  parameter int unsigned STORE_BLOCKS = STORE_BLOCKS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  req_t       req,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output rsp_t       rsp,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data
);

  localparam int unsigned BLK_W       = $clog2(STORE_BLOCKS);
  localparam int unsigned STORE_WORDS = STORE_BLOCKS * WORDS_PER_BLOCK;
  localparam int unsigned SADDR_W     = BLK_W + WSEL_W;
  localparam int unsigned CADDR_W     = LINE_W + WSEL_W;
  localparam int unsigned CNT_W       = WSEL_W + 1;
  localparam logic [31:0] STORE_BYTES = 32'(STORE_BLOCKS * BLOCK_BYTES);
  localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(WORDS_PER_BLOCK);
  localparam logic [SADDR_W-1:0] CLR_LAST  = SADDR_W'(STORE_WORDS - 1);

  state_t state, state_next;

  logic [1:0]         unit_size_log2;
  logic [CNT_W-1:0]   cnt;
  logic [SADDR_W-1:0] clr_addr;
  logic               line_valid [CACHE_LINES];

  // request as decoded at the port
  logic [BADDR_W-1:0] in_baddr;
  logic [31:0]        in_ba32;
  logic               in_oor;
  logic [BLK_W-1:0]   in_blk;
  logic [LINE_W-1:0]  in_line;
  logic [WSEL_W-1:0]  in_wsel;

  // request held for the duration of the work
  logic               is_get;
  logic [1:0]         usl_r;
  logic [BLK_W-1:0]   blk_r;
  logic [LINE_W-1:0]  line_r;
  logic [WSEL_W-1:0]  wsel_r;
  logic [BSEL_W-1:0]  off_r;
  logic [63:0]        wval_r;
  logic               hit_r;
  logic               wb_r;
  rsp_t               pend;

  // memories
  logic [BLK_W-1:0] tag_mem   [CACHE_LINES];
  logic [63:0]      cache_mem [CACHE_LINES * WORDS_PER_BLOCK];
  logic [63:0]      store_mem [STORE_WORDS];
  logic [BLK_W-1:0] tag_q;
  logic [63:0]      cache_q;
  logic [63:0]      store_q;

  logic               tag_re, tag_we;
  logic               cache_re, cache_we;
  logic [CADDR_W-1:0] cache_raddr, cache_waddr;
  logic [63:0]        cache_wdata;
  logic               store_re, store_we;
  logic [SADDR_W-1:0] store_raddr, store_waddr;
  logic [63:0]        store_wdata;

  logic              hit;
  logic              rsp_free;
  logic [WSEL_W-1:0] cnt_prev;
  logic [63:0]       merged_word;
  logic [63:0]       unit_value;
  logic              unit_unset;

  assign in_baddr = {3'b000, req.unit_index} << unit_size_log2;
  assign in_ba32  = {{(32 - BADDR_W){1'b0}}, in_baddr};
  assign in_oor   = (in_ba32 >= STORE_BYTES);
  assign in_blk   = in_ba32[BLK_W+BOFF_W-1:BOFF_W];
  assign in_line  = in_ba32[LINE_W+BOFF_W-1:BOFF_W];
  assign in_wsel  = in_ba32[BOFF_W-1:BSEL_W];

  assign hit      = line_valid[line_r] && (tag_q == blk_r);
  assign rsp_free = !rsp_valid || rsp_ready;
  assign cnt_prev = cnt[WSEL_W-1:0] - WSEL_W'(1);
  assign cfg_ready = 1'b1;

  dmbc_unit_merge u_merge (
    .unit_size_log2 (usl_r),
    .byte_off       (off_r),
    .old_word       (cache_q),
    .write_value    (wval_r),
    .new_word       (merged_word),
    .unit_value     (unit_value),
    .unset          (unit_unset)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clr_addr == CLR_LAST) state_next = S_IDLE;
      S_IDLE:   if (req_valid) state_next = in_oor ? S_RESP : S_LOOKUP;
      S_LOOKUP: begin
        if (hit) state_next = S_ACCESS;
        else     state_next = line_valid[line_r] ? S_WB : S_FILL;
      end
      S_WB:     if (cnt == CNT_LAST) state_next = S_FILL;
      S_FILL:   if (cnt == CNT_LAST) state_next = S_REREAD;
      S_REREAD: state_next = S_ACCESS;
      S_ACCESS: state_next = S_RESP;
      S_RESP:   if (rsp_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // memory controls per state
  always_comb begin
    req_ready   = 1'b0;
    tag_re      = 1'b0;
    tag_we      = 1'b0;
    cache_re    = 1'b0;
    cache_we    = 1'b0;
    cache_raddr = {in_line, in_wsel};
    cache_waddr = {line_r, wsel_r};
    cache_wdata = merged_word;
    store_re    = 1'b0;
    store_we    = 1'b0;
    store_raddr = {blk_r, cnt[WSEL_W-1:0]};
    store_waddr = clr_addr;
    store_wdata = FILL_WORD;
    unique case (state)
      S_CLEAR: begin
        store_we = 1'b1;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        tag_re    = req_valid;
        cache_re  = req_valid;
      end
      S_LOOKUP: begin
        tag_we = !hit;
      end
      S_WB: begin
        // read word n from the line while word n-1 goes to the store
        cache_re    = !cnt[WSEL_W];
        cache_raddr = {line_r, cnt[WSEL_W-1:0]};
        store_we    = (cnt != '0);
        store_waddr = {tag_q, cnt_prev};
        store_wdata = cache_q;
      end
      S_FILL: begin
        store_re    = !cnt[WSEL_W];
        cache_we    = (cnt != '0);
        cache_waddr = {line_r, cnt_prev};
        cache_wdata = store_q;
      end
      S_REREAD: begin
        cache_re    = 1'b1;
        cache_raddr = {line_r, wsel_r};
      end
      S_ACCESS: begin
        cache_we = (is_get == REQ_SET);
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      cnt            <= '0;
      clr_addr       <= '0;
      rsp_valid      <= 1'b0;
      unit_size_log2 <= USIZE_RESET;
      for (int i = 0; i < CACHE_LINES; i++) line_valid[i] <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_WB) || (state == S_FILL)) begin
        cnt <= (cnt == CNT_LAST) ? '0 : cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
      if (state == S_CLEAR) clr_addr <= clr_addr + SADDR_W'(1);
      if (tag_we) line_valid[line_r] <= 1'b1;
      if (cfg_valid) unit_size_log2 <= cfg_data;
      if ((state == S_RESP) && rsp_free) rsp_valid <= 1'b1;
      else if (rsp_ready)                rsp_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      is_get <= req.req_type;
      usl_r  <= unit_size_log2;
      blk_r  <= in_blk;
      line_r <= in_line;
      wsel_r <= in_wsel;
      off_r  <= in_ba32[BSEL_W-1:0];
      wval_r <= req.write_value;
      if (in_oor) begin
        pend.status        <= ST_RANGE;
        pend.read_value    <= '0;
        pend.was_hit       <= 1'b0;
        pend.did_writeback <= 1'b0;
      end
    end
    if (state == S_LOOKUP) begin
      hit_r <= hit;
      wb_r  <= !hit && line_valid[line_r];
    end
    if (state == S_ACCESS) begin
      pend.status        <= ((is_get == REQ_GET) && unit_unset) ? ST_UNSET : ST_OK;
      pend.read_value    <= ((is_get == REQ_GET) && !unit_unset) ? unit_value : '0;
      pend.was_hit       <= hit_r;
      pend.did_writeback <= wb_r;
    end
    if ((state == S_RESP) && rsp_free) rsp <= pend;
  end

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[line_r] <= blk_r;
    if (tag_re) tag_q <= tag_mem[in_line];
  end

  always_ff @(posedge clk) begin
    if (cache_we) cache_mem[cache_waddr] <= cache_wdata;
    if (cache_re) cache_q <= cache_mem[cache_raddr];
  end

  always_ff @(posedge clk) begin
    if (store_we) store_mem[store_waddr] <= store_wdata;
    if (store_re) store_q <= store_mem[store_raddr];
  end

`ifndef NO_ASSERTIONS
  a_miss_marks_line: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOKUP && !hit) |=> line_valid[line_r])
    else $error("line not marked valid after a miss");

  a_clear_blocks_req: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !req_ready)
    else $error("request taken during clearing pass");

  a_wb_then_fill: assert property (@(posedge clk) disable iff (rst)
    (state == S_WB && cnt == CNT_LAST) |=> (state == S_FILL && cnt == '0))
    else $error("write-back did not hand over to fill");

  a_range_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && pend.status == ST_RANGE) |->
      (pend.read_value == '0 && !pend.was_hit && !pend.did_writeback))
    else $error("out-of-range result carries data");
`endif

endmodule
